@@ hw/rtl/cdq_pkg.sv @@
// Package of shared operation codes, status codes and control types for the circular deque.
`timescale 1ns / 1ps

package cdq_pkg;

    typedef enum logic [2:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_READ       = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    // Response control that travels from the controller to the output stage.
    typedef struct packed {
        logic    done;
        t_status status;
        logic    fwd_front;
        logic    fwd_back;
    } t_resp_ctl;

endpackage

@@ hw/rtl/cdq_ram.sv @@
// Ring storage: one write port and two registered read ports.
`timescale 1ns / 1ps

module cdq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr_a,
    input  logic [AW-1:0]    i_rd_addr_b,
    output logic [WIDTH-1:0] o_rd_data_a,
    output logic [WIDTH-1:0] o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

@@ hw/rtl/cdq_ctrl.sv @@
// Pointer and count control: decodes operations and drives the ring storage addresses.
`timescale 1ns / 1ps

module cdq_ctrl import cdq_pkg::*; #(
    parameter int CAPACITY = 16,
    parameter int AW       = 4,
    parameter int CW       = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [2:0]    i_mode,
    output logic          o_busy,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [AW-1:0] o_rd_front_addr,
    output logic [AW-1:0] o_rd_back_addr,
    output logic [CW-1:0] o_count,
    output t_resp_ctl     o_resp
);

    localparam logic [AW-1:0] LAST_POS = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
    localparam logic [CW:0]   CAP_SUM  = (CW+1)'(CAPACITY);

    logic [AW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic          r_busy;
    t_resp_ctl     r_resp;

    logic          accept, full, empty;
    t_status       status;
    logic [AW-1:0] prev_pos, next_pos;

    // Position offset into the ring; both operands stay below CAPACITY, so the
    // sum stays below twice CAPACITY and one subtract brings it back.
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] pos,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(pos) + (CW+1)'(off);
        if (sum >= CAP_SUM) begin
            sum = sum - CAP_SUM;
        end
        return sum[AW-1:0];
    endfunction

    always_comb begin
        accept   = i_start && !r_busy;
        full     = (r_count == CAP_CNT);
        empty    = (r_count == '0);
        prev_pos = (r_front == '0) ? LAST_POS : r_front - 1'b1;
        next_pos = (r_front == LAST_POS) ? '0 : r_front + 1'b1;

        n_front   = r_front;
        n_count   = r_count;
        o_wr_en   = 1'b0;
        o_wr_addr = r_front;
        status    = STAT_OK;

        if (accept) begin
            case (t_mode'(i_mode))
                MODE_PUSH_FRONT: begin
                    if (full) begin
                        status = STAT_FULL;
                    end else begin
                        n_front   = prev_pos;
                        o_wr_en   = 1'b1;
                        o_wr_addr = prev_pos;
                        n_count   = r_count + 1'b1;
                    end
                end
                MODE_PUSH_BACK: begin
                    if (full) begin
                        status = STAT_FULL;
                    end else begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = ring_add(r_front, r_count);
                        n_count   = r_count + 1'b1;
                    end
                end
                MODE_POP_FRONT: begin
                    if (empty) begin
                        status = STAT_EMPTY;
                    end else begin
                        n_front = next_pos;
                        n_count = r_count - 1'b1;
                    end
                end
                MODE_POP_BACK: begin
                    if (empty) begin
                        status = STAT_EMPTY;
                    end else begin
                        n_count = r_count - 1'b1;
                    end
                end
                default: begin
                    // Read only, and the unused codes behave the same way.
                end
            endcase
        end

        // Reads always target the post-operation ends of the queue.
        o_rd_front_addr = n_front;
        o_rd_back_addr  = (n_count == '0) ? n_front : ring_add(n_front, n_count - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_busy  <= 1'b1;
            r_resp  <= '{done: 1'b0, status: STAT_OK, fwd_front: 1'b0, fwd_back: 1'b0};
        end else begin
            r_front <= n_front;
            r_count <= n_count;
            r_busy  <= 1'b0;
            r_resp  <= '{done:      accept,
                         status:    status,
                         fwd_front: o_wr_en && (o_wr_addr == o_rd_front_addr),
                         fwd_back:  o_wr_en && (o_wr_addr == o_rd_back_addr)};
        end
    end

    assign o_busy  = r_busy;
    assign o_count = r_count;
    assign o_resp  = r_resp;

endmodule

@@ hw/rtl/circular_deque.sv @@
// Top level of the circular deque: controller, ring storage and result stage.
//
//   Channel   Direction  Transfer edge            Signals
//   command   in         start && !busy           i_mode, i_value
//   result    out        every edge with o_done   o_status, o_front_value, o_back_value,
//                                                 o_item_count, o_is_empty, o_is_full
//
// A command is taken at a rising edge with start high and busy low. Its result
// appears on the next cycle, strobed by o_done for exactly one cycle. Busy is
// low in every cycle after reset, so a new command may be taken in every cycle,
// including the cycle that presents the previous result; the rate is set by the
// single read-modify-write pass through the ring storage. The receiver cannot
// stall: each result is gone after its one cycle. Reset is synchronous and
// active low; busy stays high through the cycle in which reset is released. The
// storage needs no clearing pass, because only written entries are ever shown.
`timescale 1ns / 1ps

module circular_deque import cdq_pkg::*; #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [2:0]                      i_mode,
    input  logic [DATA_WIDTH-1:0]           i_value,
    output logic                            o_done,
    output logic [1:0]                      o_status,
    output logic [DATA_WIDTH-1:0]           o_front_value,
    output logic [DATA_WIDTH-1:0]           o_back_value,
    output logic [$clog2(CAPACITY+1)-1:0]   o_item_count,
    output logic                            o_is_empty,
    output logic                            o_is_full
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_front_addr;
    logic [AW-1:0]         rd_back_addr;
    logic [DATA_WIDTH-1:0] rd_front_data;
    logic [DATA_WIDTH-1:0] rd_back_data;
    logic [CW-1:0]         count;
    t_resp_ctl             resp;

    // Last input value, used when the entry read this cycle is the one being
    // written at the same edge (the storage returns the old contents then).
    logic [DATA_WIDTH-1:0] r_fwd_data;

    cdq_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_mode          (i_mode),
        .o_busy          (busy),
        .o_wr_en         (wr_en),
        .o_wr_addr       (wr_addr),
        .o_rd_front_addr (rd_front_addr),
        .o_rd_back_addr  (rd_back_addr),
        .o_count         (count),
        .o_resp          (resp)
    );

    cdq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH),
        .AW    (AW)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (i_value),
        .i_rd_addr_a (rd_front_addr),
        .i_rd_addr_b (rd_back_addr),
        .o_rd_data_a (rd_front_data),
        .o_rd_data_b (rd_back_data)
    );

    always_ff @(posedge i_clk) begin
        r_fwd_data <= i_value;
    end

    // The count register already holds the post-operation value while the
    // result is shown, so the flags follow from it directly. An empty queue
    // reports zero at both ends.
    assign o_done        = resp.done;
    assign o_status      = resp.status;
    assign o_item_count  = count;
    assign o_is_empty    = (count == '0);
    assign o_is_full     = (count == CAP_CNT);
    assign o_front_value = o_is_empty     ? '0 :
                           resp.fwd_front ? r_fwd_data : rd_front_data;
    assign o_back_value  = o_is_empty     ? '0 :
                           resp.fwd_back  ? r_fwd_data : rd_back_data;

    // Every accepted command produces exactly one result on the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("accepted command produced no result");

    a_no_stray_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_done)
        else $error("result without an accepted command");

    // A refused push can only come from a full queue, a refused pop from an empty one.
    a_full_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == STAT_FULL)) |-> o_is_full)
        else $error("full status while the queue is not full");

    a_empty_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == STAT_EMPTY)) |-> o_is_empty)
        else $error("empty status while the queue is not empty");

    // With one item held, both read ports and the forwarding path must agree.
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_item_count == CW'(1))) |-> (o_front_value == o_back_value))
        else $error("front and back differ with a single item held");

endmodule

@@ dv/circular_deque_checker.sv @@
// Checker for the circular deque: tracks the queue contents and compares every result.
`timescale 1ns / 1ps

module circular_deque_checker import cdq_pkg::*; #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  logic [2:0]                      i_mode,
    input  logic [DATA_WIDTH-1:0]           i_value,
    input  logic                            i_done,
    input  logic [1:0]                      i_status,
    input  logic [DATA_WIDTH-1:0]           i_front_value,
    input  logic [DATA_WIDTH-1:0]           i_back_value,
    input  logic [$clog2(CAPACITY+1)-1:0]   i_item_count,
    input  logic                            i_is_empty,
    input  logic                            i_is_full,
    output int                              o_fail_count,
    output int                              o_pending
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef struct {
        t_status               status;
        logic [DATA_WIDTH-1:0] front;
        logic [DATA_WIDTH-1:0] back;
        logic [CW-1:0]         count;
        logic                  empty;
        logic                  full;
    } t_deque_view;

    t_deque_view           view_q[$];
    logic [DATA_WIDTH-1:0] ring_mem [CAPACITY];
    int                    head;
    int                    held;

    // Applies one command to the tracked queue and returns the view it leaves.
    task automatic apply_command(input logic [2:0] mode, input logic [DATA_WIDTH-1:0] value,
                                 output t_deque_view view);
        t_status st;
        st = STAT_OK;
        case (mode)
            MODE_PUSH_FRONT: begin
                if (held == CAPACITY) begin
                    st = STAT_FULL;
                end else begin
                    head = (head + CAPACITY - 1) % CAPACITY;
                    ring_mem[head] = value;
                    held++;
                end
            end
            MODE_PUSH_BACK: begin
                if (held == CAPACITY) begin
                    st = STAT_FULL;
                end else begin
                    ring_mem[(head + held) % CAPACITY] = value;
                    held++;
                end
            end
            MODE_POP_FRONT: begin
                if (held == 0) begin
                    st = STAT_EMPTY;
                end else begin
                    head = (head + 1) % CAPACITY;
                    held--;
                end
            end
            MODE_POP_BACK: begin
                if (held == 0) begin
                    st = STAT_EMPTY;
                end else begin
                    held--;
                end
            end
            default: ;
        endcase
        view.status = st;
        view.count  = CW'(held);
        view.empty  = (held == 0);
        view.full   = (held == CAPACITY);
        if (held == 0) begin
            view.front = '0;
            view.back  = '0;
        end else begin
            view.front = ring_mem[head];
            view.back  = ring_mem[(head + held - 1) % CAPACITY];
        end
    endtask

    function automatic int check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_deque_view want;
        t_deque_view next_view;
        int          bad;
        bad = 0;
        if (!i_rst_n) begin
            head = 0;
            held = 0;
            view_q.delete();
            o_pending    <= 0;
            o_fail_count <= 0;
        end else begin
            // The result of the previous transfer is compared before this edge's command
            // is applied, so both may land on the same edge.
            if (i_done) begin
                if (view_q.size() == 0) begin
                    $display("%0t: result with no command outstanding", $time);
                    bad++;
                end else begin
                    want = view_q.pop_front();
                    bad += check_field("status", want.status, i_status);
                    bad += check_field("front_value", want.front, i_front_value);
                    bad += check_field("back_value", want.back, i_back_value);
                    bad += check_field("item_count", want.count, i_item_count);
                    bad += check_field("is_empty", want.empty, i_is_empty);
                    bad += check_field("is_full", want.full, i_is_full);
                end
            end
            if (i_start && !i_busy) begin
                apply_command(i_mode, i_value, next_view);
                view_q.push_back(next_view);
            end
            o_pending    <= view_q.size();
            o_fail_count <= o_fail_count + bad;
        end
    end

endmodule

@@ dv/circular_deque_tb.sv @@
// Testbench top for the circular deque: clock, reset, command stimulus and final verdict.
`timescale 1ns / 1ps

module circular_deque_tb;
    import cdq_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int DATA_WIDTH   = 32;
    localparam int CW           = $clog2(CAPACITY + 1);
    localparam int RANDOM_ITEMS = 925;
    localparam int CYCLE_LIMIT  = 200000;

    // Mode codes the block does not name; it must treat them as a plain read.
    localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
    localparam logic [2:0] MODE_SPARE_MID = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

    // Bias of a random stretch: toward filling, toward draining, or neither.
    typedef enum int {BIAS_FILL, BIAS_DRAIN, BIAS_EVEN} t_bias;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start   = 1'b0;
    logic [2:0]            i_mode  = MODE_READ;
    logic [DATA_WIDTH-1:0] i_value = '0;
    logic                  busy;
    logic                  o_done;
    logic [1:0]            o_status;
    logic [DATA_WIDTH-1:0] o_front_value;
    logic [DATA_WIDTH-1:0] o_back_value;
    logic [CW-1:0]         o_item_count;
    logic                  o_is_empty;
    logic                  o_is_full;
    int                    fail_count;
    int                    pending;
    int                    cycle_count = 0;

    always #2 i_clk = ~i_clk;

    circular_deque #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_value       (i_value),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value),
        .o_item_count  (o_item_count),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full)
    );

    circular_deque_checker #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_mode        (i_mode),
        .i_value       (i_value),
        .i_done        (o_done),
        .i_status      (o_status),
        .i_front_value (o_front_value),
        .i_back_value  (o_back_value),
        .i_item_count  (o_item_count),
        .i_is_empty    (o_is_empty),
        .i_is_full     (o_is_full),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // A hung handshake or a lost result ends the run here. The limit lies far above
    // the slowest correct run, in which every command waits out the longest gap.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("circular_deque: mismatch");
            $finish;
        end
    end

    // Presents one command after an idle gap and holds it until the transfer edge.
    // Busy is read right after the edge, so it is the value the block showed at that
    // edge. Start is left high on return, so back-to-back commands never drop it
    // within a time step; a gap lowers it once, at the start of the next call.
    task automatic send_command(input logic [2:0] mode, input logic [DATA_WIDTH-1:0] value,
                                input int gap_cycles);
        if (gap_cycles > 0) begin
            start <= 1'b0;
            repeat (gap_cycles) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_mode  <= mode;
        i_value <= value;
        do @(posedge i_clk); while (busy);
    endtask

    // Stops sending and waits until every outstanding result has been checked. The
    // first wait covers the lag of the checker's registered pending count.
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic int draw_gap(input bit gaps_on);
        return gaps_on ? $urandom_range(0, 18) : 0;
    endfunction

    // Mostly random data, with the all-zero and all-one words showing up often.
    function automatic logic [DATA_WIDTH-1:0] draw_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return DATA_WIDTH'($urandom);
        endcase
    endfunction

    // Picks a mode for one command of a random stretch. Pushes and pops split evenly
    // between the two ends, so the ring wraps in both directions.
    function automatic logic [2:0] draw_mode(input t_bias bias);
        int pick;
        int push_share;
        pick = $urandom_range(0, 99);
        case (bias)
            BIAS_FILL:  push_share = 70;
            BIAS_DRAIN: push_share = 22;
            default:    push_share = 46;
        endcase
        if (pick < push_share) begin
            return $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
        end else if (pick < 92) begin
            return $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
        end else if (pick < 97) begin
            return MODE_READ;
        end
        return 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    endfunction

    initial begin
        int    sent;
        int    stretch;
        bit    gaps_on;
        bit    paused;
        t_bias bias;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Every non-push command on the empty queue first: both pops must be
        // refused, and the read and the spare codes must report an empty view.
        gaps_on = 1'b1;
        send_command(MODE_READ, '1, draw_gap(gaps_on));
        send_command(MODE_POP_FRONT, '0, draw_gap(gaps_on));
        send_command(MODE_POP_BACK, '0, draw_gap(gaps_on));
        send_command(MODE_SPARE_LO, '1, draw_gap(gaps_on));
        send_command(MODE_SPARE_MID, '1, draw_gap(gaps_on));
        send_command(MODE_SPARE_HI, '1, draw_gap(gaps_on));

        // Fill from both ends. Pushing at the front from index zero wraps the ring
        // backward at once; the extremes of the data word go in at the first and last
        // push. Back-to-back transfers here, no gaps.
        for (int k = 0; k < CAPACITY / 2; k++) begin
            send_command(MODE_PUSH_FRONT, (k == 0) ? '0 : draw_value(), 0);
        end
        for (int k = 0; k < CAPACITY / 2; k++) begin
            send_command(MODE_PUSH_BACK, (k == CAPACITY / 2 - 1) ? '1 : draw_value(), 0);
        end

        // A full queue must refuse both pushes and stay as it is.
        send_command(MODE_PUSH_FRONT, '1, draw_gap(gaps_on));
        send_command(MODE_PUSH_BACK, '0, draw_gap(gaps_on));
        send_command(MODE_READ, '0, draw_gap(gaps_on));
        send_command(MODE_POP_FRONT, '1, draw_gap(gaps_on));
        send_command(MODE_POP_BACK, '1, draw_gap(gaps_on));

        // Random part in stretches of 20 to 60 commands. Each stretch leans toward
        // filling, draining or neither, so the queue keeps running into both the full
        // and the empty edge, and about a quarter of the stretches have no idle gaps.
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            stretch = $urandom_range(20, 60);
            bias    = t_bias'($urandom_range(0, 2));
            gaps_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < stretch && sent < RANDOM_ITEMS; k++) begin
                send_command(draw_mode(bias), draw_value(), draw_gap(gaps_on));
                sent++;
            end
            // Once, halfway through, let every outstanding result come back before
            // sending on.
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                drain_results();
                paused = 1'b1;
            end
        end

        // Wait for the last results, then wait on to catch a stray strobe.
        drain_results();
        repeat (4) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("circular_deque: match");
        end else begin
            $display("circular_deque: mismatch");
        end
        $finish;
    end

endmodule
